[hdl/usc_pkg.sv]
// Types, constants and the control program of the seconds-to-calendar converter.
`timescale 1ns / 1ps

package usc_pkg;

  typedef logic [3:0] upc_t;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_DIV,
    OP_SEC,
    OP_MIN,
    OP_HOUR,
    OP_WDAY,
    OP_YEAR,
    OP_MONTH,
    OP_DONE
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_WAIT,
    C_YEAR,
    C_MONTH
  } cond_e;

  typedef struct packed {
    op_e         op;
    cond_e       cond;
    upc_t        target;
    logic [5:0]  divisor;
    logic [31:0] recip;
    logic [5:0]  shift;
  } ctrl_t;

  localparam upc_t PC_IDLE  = 4'd0;
  localparam upc_t PC_YEAR  = 4'd9;
  localparam upc_t PC_MONTH = 4'd10;
  localparam upc_t PC_DONE  = 4'd11;

  localparam logic [5:0] SEC_PER_MIN  = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR = 6'd60;
  localparam logic [5:0] HOUR_PER_DAY = 6'd24;
  localparam logic [5:0] DAY_PER_WEEK = 6'd7;

  // Each constant division multiplies by a rounded-up reciprocal and shifts; the
  // rounding error stays below one unit over the whole range of its operand.
  localparam logic [31:0] RECIP_60 = 32'h8888_8889;
  localparam logic [5:0]  SHIFT_60 = 6'd37;
  localparam logic [31:0] RECIP_24 = 32'd699051;
  localparam logic [5:0]  SHIFT_24 = 6'd24;
  localparam logic [31:0] RECIP_7  = 32'd74899;
  localparam logic [5:0]  SHIFT_7  = 6'd19;

  localparam logic [31:0] EPOCH_WEEKDAY = 32'd4;
  localparam logic [7:0]  EPOCH_YEAR_OFFSET = 8'd70;
  localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
  localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;
  localparam logic [3:0]  LAST_MONTH = 4'd11;

  // A year is given as its offset from 1900, which is divisible by 4 and by 25 and is 12 mod 16.
  function automatic logic leap_year(logic [7:0] yoff);
    logic by25;
    by25 = 1'b0;
    for (int k = 0; k <= 10; k++) begin
      if (yoff == 8'(25 * k)) begin
        by25 = 1'b1;
      end
    end
    return (yoff[1:0] == 2'd0) && (!by25 || (yoff[3:0] == 4'd4));
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd1:                     len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
      4'd0, 4'd2, 4'd4, 4'd6,
      4'd7, 4'd9, 4'd11:        len = 5'd31;
      default:                  len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t w;
    w = '{op: OP_DONE, cond: C_ALWAYS, target: PC_IDLE, divisor: 6'd0,
          recip: 32'd0, shift: 6'd0};
    unique case (pc)
      4'd0:  w = '{op: OP_WAIT, cond: C_WAIT, target: PC_IDLE, divisor: 6'd0,
                   recip: 32'd0, shift: 6'd0};
      4'd1:  w = '{op: OP_DIV, cond: C_NEXT, target: PC_IDLE, divisor: SEC_PER_MIN,
                   recip: RECIP_60, shift: SHIFT_60};
      4'd2:  w = '{op: OP_SEC, cond: C_NEXT, target: PC_IDLE, divisor: SEC_PER_MIN,
                   recip: 32'd0, shift: 6'd0};
      4'd3:  w = '{op: OP_DIV, cond: C_NEXT, target: PC_IDLE, divisor: MIN_PER_HOUR,
                   recip: RECIP_60, shift: SHIFT_60};
      4'd4:  w = '{op: OP_MIN, cond: C_NEXT, target: PC_IDLE, divisor: MIN_PER_HOUR,
                   recip: 32'd0, shift: 6'd0};
      4'd5:  w = '{op: OP_DIV, cond: C_NEXT, target: PC_IDLE, divisor: HOUR_PER_DAY,
                   recip: RECIP_24, shift: SHIFT_24};
      4'd6:  w = '{op: OP_HOUR, cond: C_NEXT, target: PC_IDLE, divisor: HOUR_PER_DAY,
                   recip: 32'd0, shift: 6'd0};
      4'd7:  w = '{op: OP_DIV, cond: C_NEXT, target: PC_IDLE, divisor: DAY_PER_WEEK,
                   recip: RECIP_7, shift: SHIFT_7};
      4'd8:  w = '{op: OP_WDAY, cond: C_NEXT, target: PC_IDLE, divisor: DAY_PER_WEEK,
                   recip: 32'd0, shift: 6'd0};
      4'd9:  w = '{op: OP_YEAR, cond: C_YEAR, target: PC_YEAR, divisor: 6'd0,
                   recip: 32'd0, shift: 6'd0};
      4'd10: w = '{op: OP_MONTH, cond: C_MONTH, target: PC_MONTH, divisor: 6'd0,
                   recip: 32'd0, shift: 6'd0};
      4'd11: w = '{op: OP_DONE, cond: C_ALWAYS, target: PC_IDLE, divisor: 6'd0,
                   recip: 32'd0, shift: 6'd0};
      default: w = '{op: OP_DONE, cond: C_ALWAYS, target: PC_IDLE, divisor: 6'd0,
                     recip: 32'd0, shift: 6'd0};
    endcase
    return w;
  endfunction

endpackage

[hdl/unix_seconds_to_calendar.sv]
// Top level: converts Unix seconds to broken-down Gregorian calendar time.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low, and busy then stays high
// until the item is converted. The result appears on the output ports for one
// cycle with done_o high, in the first cycle with busy low, and the next item
// can be taken at the end of that cycle. The work is done by four constant
// divisions, each a reciprocal multiplication followed by a remainder step in
// the next cycle, and by the year and month loops, which take one year or one
// month off per cycle. The receiver cannot stall the block, so every result
// must be captured on its done_o cycle.
module unix_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] unix_seconds_i,
  output logic        done_o,
  output logic [5:0]  second_of_minute_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [4:0]  hour_of_day_o,
  output logic [2:0]  weekday_o,
  output logic [8:0]  day_of_year_o,
  output logic [7:0]  years_since_1900_o,
  output logic [3:0]  month_index_o,
  output logic [4:0]  day_of_month_o
);

  usc_pkg::upc_t  pc_q, pc_d;
  logic           done_q, done_d;
  usc_pkg::ctrl_t w;

  logic [31:0] num_q, num_d;
  logic [31:0] quo_q, quo_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic [2:0]  wday_q, wday_d;
  logic [15:0] days_q, days_d;
  logic [8:0]  doy_q, doy_d;
  logic [7:0]  yoff_q, yoff_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  dom_q, dom_d;

  logic [63:0] prod;
  logic [11:0] low_mul;
  logic [5:0]  rem;
  logic        leap;
  logic [8:0]  yr_len;
  logic [4:0]  mo_len;
  logic        year_more;
  logic        month_more;
  logic        jump;

  always_comb begin
    w          = usc_pkg::ucode(pc_q);
    prod       = {32'd0, num_q} * {32'd0, w.recip};
    low_mul    = {6'd0, quo_q[5:0]} * {6'd0, w.divisor};
    rem        = num_q[5:0] - low_mul[5:0];
    leap       = usc_pkg::leap_year(yoff_q);
    yr_len     = leap ? usc_pkg::DAYS_LEAP_YEAR : usc_pkg::DAYS_COMMON_YEAR;
    mo_len     = usc_pkg::month_len(month_q, leap);
    year_more  = days_q >= 16'(yr_len);
    month_more = (month_q < usc_pkg::LAST_MONTH) && (days_q >= 16'(mo_len));

    done_d  = 1'b0;
    num_d   = num_q;
    quo_d   = quo_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    wday_d  = wday_q;
    days_d  = days_q;
    doy_d   = doy_q;
    yoff_d  = yoff_q;
    month_d = month_q;
    dom_d   = dom_q;

    unique case (w.op)
      usc_pkg::OP_WAIT: begin
        if (start) begin
          num_d = unix_seconds_i;
        end
      end
      usc_pkg::OP_DIV: begin
        quo_d = 32'(prod >> w.shift);
      end
      usc_pkg::OP_SEC: begin
        sec_d = rem;
        num_d = quo_q;
      end
      usc_pkg::OP_MIN: begin
        min_d = rem;
        num_d = quo_q;
      end
      usc_pkg::OP_HOUR: begin
        hour_d = rem[4:0];
        days_d = quo_q[15:0];
        num_d  = quo_q + usc_pkg::EPOCH_WEEKDAY;
        yoff_d = usc_pkg::EPOCH_YEAR_OFFSET;
      end
      usc_pkg::OP_WDAY: begin
        wday_d  = rem[2:0];
        month_d = 4'd0;
      end
      usc_pkg::OP_YEAR: begin
        if (year_more) begin
          days_d = days_q - 16'(yr_len);
          yoff_d = yoff_q + 8'd1;
        end else begin
          doy_d = days_q[8:0];
        end
      end
      usc_pkg::OP_MONTH: begin
        if (month_more) begin
          days_d  = days_q - 16'(mo_len);
          month_d = month_q + 4'd1;
        end
      end
      usc_pkg::OP_DONE: begin
        done_d = 1'b1;
        dom_d  = days_q[4:0] + 5'd1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase

    unique case (w.cond)
      usc_pkg::C_NEXT:   jump = 1'b0;
      usc_pkg::C_ALWAYS: jump = 1'b1;
      usc_pkg::C_WAIT:   jump = !start;
      usc_pkg::C_YEAR:   jump = year_more;
      usc_pkg::C_MONTH:  jump = month_more;
      default:           jump = 1'b1;
    endcase

    pc_d = jump ? w.target : usc_pkg::upc_t'(pc_q + 4'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= usc_pkg::PC_IDLE;
      done_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    quo_q   <= quo_d;
    sec_q   <= sec_d;
    min_q   <= min_d;
    hour_q  <= hour_d;
    wday_q  <= wday_d;
    days_q  <= days_d;
    doy_q   <= doy_d;
    yoff_q  <= yoff_d;
    month_q <= month_d;
    dom_q   <= dom_d;
  end

  assign busy               = pc_q != usc_pkg::PC_IDLE;
  assign done_o             = done_q;
  assign second_of_minute_o = sec_q;
  assign minute_of_hour_o   = min_q;
  assign hour_of_day_o      = hour_q;
  assign weekday_o          = wday_q;
  assign day_of_year_o      = doy_q;
  assign years_since_1900_o = yoff_q;
  assign month_index_o      = month_q;
  assign day_of_month_o     = dom_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not start work");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_pc_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= usc_pkg::PC_DONE) else $error("step counter out of program");

  a_done_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (second_of_minute_o < 6'd60) && (minute_of_hour_o < 6'd60) &&
               (hour_of_day_o < 5'd24) && (weekday_o < 3'd7) &&
               (month_index_o < 4'd12) && (day_of_month_o != 5'd0))
    else $error("result field out of range");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the Unix seconds to Gregorian calendar converter.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned SECONDS_PER_DAY = 86400;

  typedef struct {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [8:0] yday;
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] mday;
  } calendar_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] unix_seconds_i = '0;
  logic        done_o;
  logic [5:0]  second_of_minute_o;
  logic [5:0]  minute_of_hour_o;
  logic [4:0]  hour_of_day_o;
  logic [2:0]  weekday_o;
  logic [8:0]  day_of_year_o;
  logic [7:0]  years_since_1900_o;
  logic [3:0]  month_index_o;
  logic [4:0]  day_of_month_o;

  calendar_t   pending_dates[$];
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;

  unix_seconds_to_calendar dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .unix_seconds_i     (unix_seconds_i),
    .done_o             (done_o),
    .second_of_minute_o (second_of_minute_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .hour_of_day_o      (hour_of_day_o),
    .weekday_o          (weekday_o),
    .day_of_year_o      (day_of_year_o),
    .years_since_1900_o (years_since_1900_o),
    .month_index_o      (month_index_o),
    .day_of_month_o     (day_of_month_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic gregorian_leap(input int unsigned year);
    return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned month, input logic leap);
    int unsigned n;
    case (month)
      1: n = leap ? 29 : 28;
      3, 5, 8, 10: n = 30;
      default: n = 31;
    endcase
    return n;
  endfunction

  function automatic calendar_t calendar_of(input logic [31:0] secs);
    calendar_t   c;
    int unsigned rest;
    int unsigned days;
    int unsigned year;
    int unsigned month;
    logic        leap;
    rest = secs;
    c.second = 6'(rest % 60);
    rest = rest / 60;
    c.minute = 6'(rest % 60);
    rest = rest / 60;
    c.hour = 5'(rest % 24);
    days = rest / 24;
    // The epoch day was a Thursday.
    c.weekday = 3'((days + 4) % 7);
    year = 1970;
    leap = gregorian_leap(year);
    while (days >= (leap ? 366 : 365)) begin
      days = days - (leap ? 366 : 365);
      year++;
      leap = gregorian_leap(year);
    end
    c.yday = 9'(days);
    c.year = 8'(year - 1900);
    month = 0;
    while (month < 11 && days >= month_days(month, leap)) begin
      days = days - month_days(month, leap);
      month++;
    end
    c.month = 4'(month);
    c.mday = 5'(days + 1);
    return c;
  endfunction

  // Results are matched before new items are queued, since a result and the next
  // item can meet on the same edge.
  always @(posedge clk_i) begin : check_results
    calendar_t want;
    logic      bad;
    logic      accepted;
    accepted = rst_ni && start && busy === 1'b0;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_dates.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: result with no item waiting: %0d-%0d-%0d %0d:%0d:%0d", $realtime,
                   years_since_1900_o, month_index_o, day_of_month_o, hour_of_day_o,
                   minute_of_hour_o, second_of_minute_o);
        end
      end else begin
        want = pending_dates.pop_front();
        bad = 1'b0;
        if (second_of_minute_o !== want.second) bad = 1'b1;
        if (minute_of_hour_o !== want.minute) bad = 1'b1;
        if (hour_of_day_o !== want.hour) bad = 1'b1;
        if (weekday_o !== want.weekday) bad = 1'b1;
        if (day_of_year_o !== want.yday) bad = 1'b1;
        if (years_since_1900_o !== want.year) bad = 1'b1;
        if (month_index_o !== want.month) bad = 1'b1;
        if (day_of_month_o !== want.mday) bad = 1'b1;
        if (bad) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: expected y%0d m%0d d%0d yd%0d wd%0d %0d:%0d:%0d", $realtime,
                     want.year, want.month, want.mday, want.yday, want.weekday,
                     want.hour, want.minute, want.second);
            $display("%0t:   actual y%0d m%0d d%0d yd%0d wd%0d %0d:%0d:%0d", $realtime,
                     years_since_1900_o, month_index_o, day_of_month_o, day_of_year_o,
                     weekday_o, hour_of_day_o, minute_of_hour_o, second_of_minute_o);
          end
        end
      end
    end
    if (accepted) begin
      pending_dates.push_back(calendar_of(unix_seconds_i));
    end
    if (accepted || (rst_ni && done_o === 1'b1)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
    end
    $display("unix_seconds_to_calendar verification failed");
    $finish;
  end

  task automatic send_item(input logic [31:0] secs);
    start <= 1'b1;
    unix_seconds_i <= secs;
    @(posedge clk_i);
    while (busy !== 1'b0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic sender_gap(input int unsigned idle_pct);
    int unsigned len;
    if ($urandom_range(99) < idle_pct) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(21, 300) : $urandom_range(1, 20);
      start <= 1'b0;
      unix_seconds_i <= $urandom;
      repeat (len) @(posedge clk_i);
    end
  endtask

  // The item taken on this edge is queued by the checker within the same step, so
  // the queue is looked at only from the next edge on.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_dates.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] random_seconds();
    logic [31:0] base;
    base = $urandom;
    // Some items land right around midnight, where the seconds, minutes and hours roll over and the day changes.
    if ($urandom_range(99) < 30) begin
      base = base - (base % SECONDS_PER_DAY) + $urandom_range(2) - 1;
    end
    return base;
  endfunction

  task automatic test_epoch_and_limits();
    send_item(32'd0);
    send_item(32'hFFFF_FFFF);
    send_item(32'h7FFF_FFFF);
    send_item(32'h8000_0000);
    send_item(32'd4291747200);
    send_item(32'd31535999);
  endtask

  task automatic test_time_of_day();
    send_item(32'd59);
    send_item(32'd60);
    send_item(32'd3599);
    send_item(32'd3600);
    send_item(32'd86399);
    send_item(32'd86400);
    send_item(32'd259200);
  endtask

  // Leap days in an ordinary leap year, in 2000 and around 2100, which is not one.
  task automatic test_leap_rules();
    send_item(32'd68169600);
    send_item(32'd68256000);
    send_item(32'd946684799);
    send_item(32'd946684800);
    send_item(32'd951782400);
    send_item(32'd951868800);
    send_item(32'd978307199);
    send_item(32'd4107456000);
    send_item(32'd4107542400);
    send_item(32'd4133980799);
  endtask

  task automatic test_drain_pause();
    repeat (5) send_item(random_seconds());
    wait_drained();
    repeat (5) send_item(random_seconds());
  endtask

  task automatic test_random(input int unsigned count, input int unsigned idle_pct);
    repeat (count) begin
      sender_gap(idle_pct);
      send_item(random_seconds());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_epoch_and_limits();
    test_time_of_day();
    test_leap_rules();
    test_random(190, 0);
    test_drain_pause();
    test_random(190, 59);
    test_random(190, 36);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_dates.size() == 0) begin
      $display("unix_seconds_to_calendar verification clean");
    end else begin
      $display("unix_seconds_to_calendar verification failed");
    end
    $finish;
  end

endmodule
